[src/rfa_pkg.sv]
// Package for the rational fraction ALU: payload structs, commands and status codes.
// Shared by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package rfa_pkg;
  localparam int DefWidth = 32;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OVF  = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] num_a;
    logic [31:0] den_a;
    logic [31:0] num_b;
    logic [31:0] den_b;
  } in_item_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_LOAD   = 4'd1,
    OP_GSETUP = 4'd2,
    OP_DSTART = 4'd3,
    OP_GSTEP  = 4'd4,
    OP_DIVA   = 4'd5,
    OP_DIVB   = 4'd6,
    OP_LCM    = 4'd7,
    OP_SCALEA = 4'd8,
    OP_SCALEB = 4'd9,
    OP_MULN   = 4'd10,
    OP_MULD   = 4'd11,
    OP_RSETUP = 4'd12,
    OP_DIVN   = 4'd13,
    OP_DIVD   = 4'd14,
    OP_FINAL  = 4'd15
  } op_t;

  typedef struct packed {
    op_t  op;
  } ctrl_t;

  typedef struct packed {
    logic bad;
    logic addsub;
    logic y_zero;
    logic n_zero;
    logic div_done;
  } stat_t;
endpackage
`default_nettype wire

[src/rfa_ctrl.sv]
// Controller state machine for the rational fraction ALU.
// Sequences the datapath through GCD, scaling and reduction; uses rfa_pkg.
`default_nettype none
module rfa_ctrl
  import rfa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  output logic       busy,
  output logic       done,
  output ctrl_t      ctrl,
  input  stat_t      stat
);
  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_CHECK = 15'b000000000000010,
    S_MUL1  = 15'b000000000000100,
    S_MUL2  = 15'b000000000001000,
    S_GCHK  = 15'b000000000010000,
    S_GDIV  = 15'b000000000100000,
    S_ADIV  = 15'b000000001000000,
    S_BDIV  = 15'b000000010000000,
    S_SCA   = 15'b000000100000000,
    S_SCB   = 15'b000001000000000,
    S_RSET  = 15'b000010000000000,
    S_NDIV  = 15'b000100000000000,
    S_DDIV  = 15'b001000000000000,
    S_FIN   = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   redu_r, redu_nxt;

  always_comb begin
    state_nxt = state_r;
    redu_nxt  = redu_r;
    ctrl.op   = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctrl.op = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.bad) begin
          state_nxt = S_FIN;
        end else if (stat.addsub) begin
          ctrl.op = OP_GSETUP;
          redu_nxt = 1'b0;
          state_nxt = S_GCHK;
        end else begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        ctrl.op = OP_MULN;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        ctrl.op = OP_MULD;
        state_nxt = S_RSET;
      end
      S_GCHK: begin
        if (stat.y_zero) begin
          if (redu_r) begin
            ctrl.op = OP_DIVN;
            state_nxt = S_NDIV;
          end else begin
            ctrl.op = OP_DIVA;
            state_nxt = S_ADIV;
          end
        end else begin
          ctrl.op = OP_DSTART;
          state_nxt = S_GDIV;
        end
      end
      S_GDIV: begin
        if (stat.div_done) begin
          ctrl.op = OP_GSTEP;
          state_nxt = S_GCHK;
        end
      end
      S_ADIV: begin
        if (stat.div_done) begin
          ctrl.op = OP_DIVB;
          state_nxt = S_BDIV;
        end
      end
      S_BDIV: begin
        if (stat.div_done) begin
          ctrl.op = OP_LCM;
          state_nxt = S_SCA;
        end
      end
      S_SCA: begin
        ctrl.op = OP_SCALEA;
        state_nxt = S_SCB;
      end
      S_SCB: begin
        ctrl.op = OP_SCALEB;
        state_nxt = S_RSET;
      end
      S_RSET: begin
        if (stat.n_zero) begin
          state_nxt = S_FIN;
        end else begin
          ctrl.op = OP_RSETUP;
          redu_nxt = 1'b1;
          state_nxt = S_GCHK;
        end
      end
      S_NDIV: begin
        if (stat.div_done) begin
          ctrl.op = OP_DIVD;
          state_nxt = S_DDIV;
        end
      end
      S_DDIV: begin
        if (stat.div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        ctrl.op = OP_FINAL;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      redu_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      redu_r  <= redu_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_OUT);

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("controller state is not one-hot");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_start_load: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");
endmodule
`default_nettype wire

[src/rfa_dp.sv]
// Datapath for the rational fraction ALU: operand registers, multiplier,
// restoring 64-bit divider used for GCD, LCM and reduction; uses rfa_pkg.
`default_nettype none
module rfa_dp
  import rfa_pkg::*;
#(
  parameter int WIDTH = DefWidth
)(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  in_item_t   in_item,
  input  ctrl_t      ctrl,
  output stat_t      stat,
  output out_item_t  out_item
);
  localparam int CW = $clog2(64) + 1;

  logic signed [32:0] na_r, da_r, nb_r, db_r;
  logic signed [63:0] n_r, d_r;
  logic [63:0] x_r, y_r;
  logic [63:0] q_r, rem_r, dvd_r, dvs_r;
  logic [CW-1:0] cnt_r;
  logic        dbusy_r;
  logic [1:0]  cmd_r;
  logic        bad_r;
  logic [1:0]  st_r;
  logic [31:0] onum_r;
  logic [30:0] oden_r;
  logic [63:0] an_r;
  logic        neg_r;
  logic [31:0] qa_r;

  logic signed [63:0] db0, nb0, da0, na0;
  logic signed [63:0] na_n, da_n, nb_n, db_n;
  logic signed [32:0] mul_x, mul_y;
  logic signed [65:0] mul_p;
  logic signed [63:0] prod;
  logic        is_mul;
  logic        div_start;
  logic [63:0] dvd_ld, dvs_ld;
  logic [64:0] trial;
  logic [63:0] lim;

  function automatic logic signed [63:0] sx(input logic [31:0] v);
    logic [63:0] t;
    t = 64'(v[WIDTH-1:0]);
    if (v[WIDTH-1]) begin
      t = t - (64'd1 << WIDTH);
    end
    return signed'(t);
  endfunction

  assign na0 = sx(in_item.num_a);
  assign da0 = sx(in_item.den_a);
  assign nb0 = sx(in_item.num_b);
  assign db0 = sx(in_item.den_b);

  assign na_n = (da0 < 0) ? -na0 : na0;
  assign da_n = (da0 < 0) ? -da0 : da0;
  assign nb_n = (db0 < 0) ? -nb0 : nb0;
  assign db_n = (db0 < 0) ? -db0 : db0;

  assign is_mul = (cmd_t'(cmd_r) == CMD_MUL);

  always_comb begin
    mul_x = na_r;
    mul_y = nb_r;
    unique case (ctrl.op)
      OP_MULN:   begin mul_x = na_r; mul_y = is_mul ? nb_r : db_r; end
      OP_MULD:   begin mul_x = da_r; mul_y = is_mul ? db_r : nb_r; end
      OP_LCM:    begin mul_x = {1'b0, qa_r}; mul_y = db_r; end
      OP_SCALEA: begin mul_x = na_r; mul_y = {1'b0, q_r[31:0]}; end
      OP_SCALEB: begin mul_x = nb_r; mul_y = {1'b0, qa_r}; end
      default:   begin mul_x = na_r; mul_y = nb_r; end
    endcase
  end
  assign mul_p = mul_x * mul_y;
  assign prod  = mul_p[63:0];

  always_comb begin
    div_start = 1'b1;
    dvd_ld    = x_r;
    dvs_ld    = y_r;
    unique case (ctrl.op)
      OP_DSTART: begin dvd_ld = x_r; dvs_ld = y_r; end
      OP_DIVA:   begin dvd_ld = {31'd0, da_r}; dvs_ld = x_r; end
      OP_DIVB:   begin dvd_ld = {31'd0, db_r}; dvs_ld = x_r; end
      OP_DIVN:   begin dvd_ld = an_r; dvs_ld = x_r; end
      OP_DIVD:   begin dvd_ld = 64'(d_r); dvs_ld = x_r; end
      default:   begin div_start = 1'b0; end
    endcase
  end

  assign trial = {rem_r, dvd_r[63]} - {1'b0, dvs_r};
  assign lim = 64'd1 << (WIDTH - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (div_start) begin
        dbusy_r <= 1'b1;
        cnt_r   <= CW'(64);
      end else if (dbusy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          dbusy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      dvd_r <= dvd_ld;
      dvs_r <= dvs_ld;
      rem_r <= '0;
      q_r   <= '0;
    end else if (dbusy_r) begin
      dvd_r <= {dvd_r[62:0], 1'b0};
      if (!trial[64]) begin
        rem_r <= trial[63:0];
        q_r   <= {q_r[62:0], 1'b1};
      end else begin
        rem_r <= {rem_r[62:0], dvd_r[63]};
        q_r   <= {q_r[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        cmd_r <= in_item.command;
        bad_r <= (da0 == 0) || (db0 == 0) ||
                 (cmd_t'(in_item.command) == CMD_DIV && nb0 == 0);
        na_r <= na_n[32:0];
        da_r <= da_n[32:0];
        nb_r <= nb_n[32:0];
        db_r <= db_n[32:0];
      end
      OP_GSETUP: begin
        x_r <= {31'd0, da_r};
        y_r <= {31'd0, db_r};
      end
      OP_GSTEP: begin
        x_r <= y_r;
        y_r <= rem_r;
      end
      OP_DIVB: begin
        qa_r <= q_r[31:0];
      end
      OP_LCM: begin
        d_r <= prod;
      end
      OP_SCALEA: begin
        n_r <= prod;
      end
      OP_SCALEB: begin
        n_r <= (cmd_t'(cmd_r) == CMD_ADD) ? n_r + prod : n_r - prod;
      end
      OP_MULN: begin
        n_r <= prod;
      end
      OP_MULD: begin
        if (!is_mul && nb_r < 0) begin
          d_r <= -prod;
          n_r <= -n_r;
        end else begin
          d_r <= prod;
        end
      end
      OP_RSETUP: begin
        neg_r <= n_r < 0;
        an_r  <= (n_r < 0) ? 64'(-n_r) : 64'(n_r);
        x_r   <= (n_r < 0) ? 64'(-n_r) : 64'(n_r);
        y_r   <= 64'(d_r);
      end
      OP_DIVD: begin
        an_r <= q_r;
      end
      OP_FINAL: begin
        if (bad_r) begin
          st_r <= ST_ZERO; onum_r <= '0; oden_r <= '0;
        end else if (n_r == 0) begin
          st_r <= ST_OK; onum_r <= '0; oden_r <= 31'd1;
        end else if ((neg_r ? an_r > lim : an_r > lim - 64'd1) || q_r > lim - 64'd1) begin
          st_r <= ST_OVF; onum_r <= '0; oden_r <= '0;
        end else begin
          st_r <= ST_OK;
          onum_r <= neg_r ? 32'(-an_r) : an_r[31:0];
          oden_r <= q_r[30:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.bad      = bad_r;
  assign stat.addsub   = (cmd_t'(cmd_r) == CMD_ADD) || (cmd_t'(cmd_r) == CMD_SUB);
  assign stat.y_zero   = (y_r == '0);
  assign stat.n_zero   = (n_r == '0);
  assign stat.div_done = !dbusy_r;

  assign out_item.res_num = onum_r;
  assign out_item.res_den = oden_r;
  assign out_item.status  = st_r;
endmodule
`default_nettype wire

[src/rational_fraction_alu_top.sv]
// Top level of the rational fraction ALU: joins controller and datapath.
// Depends on rfa_pkg, rfa_ctrl and rfa_dp.
//
// Usage: drive in_item and raise start while busy is low; the transaction is
// taken at that clock edge and busy is high from the next cycle. The block holds
// one transaction at a time and ignores start while busy.
// The result appears on out_item for exactly one cycle, marked by out_valid;
// the receiver cannot stall it and must take it in that cycle.
// Timing is set by the shared 64-bit restoring divider: each Euclid step of a GCD
// is one division. Add and subtract find the GCD of the denominators, divide
// both denominators by it, form the LCM, scale both numerators, then reduce;
// multiply and divide form the numerator and denominator products, then reduce.
// Reduction finds the GCD of numerator and denominator and divides both by it.
// A zero numerator skips the reduction; a zero denominator or divide by zero
// goes straight to the result.
// busy falls after the strobe cycle, so the next transaction is taken at the
// earliest in the cycle after out_valid.
// Reset (rst_n low, synchronous) returns the controller to idle and
// abandons any transaction in flight; no result is given for it.
`default_nettype none
module rational_fraction_alu_top
  import rfa_pkg::*;
#(
  parameter int WIDTH = DefWidth
)(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);
  ctrl_t ctrl;
  stat_t stat;

  rfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (out_valid),
    .ctrl  (ctrl),
    .stat  (stat)
  );

  rfa_dp #(.WIDTH(WIDTH)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .ctrl     (ctrl),
    .stat     (stat),
    .out_item (out_item)
  );
endmodule
`default_nettype wire
